>>> rtl/tnu_pkg.sv
// ----------------------------------------------------------------------------
// tnu_pkg
// shared types and constants of the triangle normal unit
// ----------------------------------------------------------------------------
package tnu_pkg;

    localparam int CompW  = 34;   // signed component width into normalizer
    localparam int NormW  = 30;   // normalized magnitude width
    localparam int OutW   = 18;   // q1.16 output width
    localparam int SqrtW  = 31;   // root width
    localparam int QuotW  = 18;   // quotient width (2^17*m/r <= 2^17)
    localparam logic [OutW-1:0] UnitOne = 18'd65536;

    typedef logic signed [CompW-1:0] comp_t;
    typedef logic signed [OutW-1:0]  unit_t;

endpackage

>>> rtl/tnu_normalize.sv
// ----------------------------------------------------------------------------
// tnu_normalize
// pipelined unit-length scaling of a three-component vector
// ----------------------------------------------------------------------------
module tnu_normalize
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  tnu_pkg::comp_t    in_x,
    input  tnu_pkg::comp_t    in_y,
    input  tnu_pkg::comp_t    in_z,
    output logic              out_valid,
    output tnu_pkg::unit_t    out_x,
    output tnu_pkg::unit_t    out_y,
    output tnu_pkg::unit_t    out_z
);

    localparam int CW    = tnu_pkg::CompW;
    localparam int NW    = tnu_pkg::NormW;
    localparam int SW    = tnu_pkg::SqrtW;
    localparam int QW    = tnu_pkg::QuotW;
    localparam int SQS   = SW;            // root bits, one per stage
    localparam int DVS   = QW;            // quotient bits, one per stage
    localparam int DEPTH = 3 + 1 + SQS + 1 + DVS + 1;

    // stage 1: magnitudes and signs
    logic [CW-1:0] m1_reg [3];
    logic [2:0]    neg1_reg;
    // stage 2: shift amount
    logic [CW-1:0] m2_reg [3];
    logic [2:0]    neg2_reg;
    logic [5:0]    lz2_reg;
    logic          zero2_reg;
    // stage 3: normalized magnitudes and their squares
    logic [NW-1:0] m3_reg [3];
    logic [2:0]    neg3_reg;
    logic          zero3_reg;
    logic [63:0]   sq3_reg [3];

    logic [DEPTH-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end
    assign out_valid = vld_reg[DEPTH-1];

    logic [CW-1:0] mag_next [3];
    always_comb
    begin
        mag_next[0] = in_x[CW-1] ? CW'(-in_x) : CW'(in_x);
        mag_next[1] = in_y[CW-1] ? CW'(-in_y) : CW'(in_y);
        mag_next[2] = in_z[CW-1] ? CW'(-in_z) : CW'(in_z);
    end

    logic [CW-1:0] big;
    logic [5:0]    lz_next;
    always_comb
    begin
        big = m1_reg[0] | m1_reg[1] | m1_reg[2];
        lz_next = 6'd0;
        for (int i = 0; i < CW; i++)
        begin
            if (big[i])
            begin
                lz_next = 6'(i);
            end
        end
    end

    logic [NW-1:0] nm_next [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (lz2_reg >= 6'(NW - 1))
            begin
                nm_next[i] = NW'(m2_reg[i] >> (lz2_reg - 6'(NW - 1)));
            end
            else
            begin
                nm_next[i] = NW'(m2_reg[i] << (6'(NW - 1) - lz2_reg));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg   <= mag_next;
            neg1_reg <= {in_z[CW-1], in_y[CW-1], in_x[CW-1]};
            m2_reg    <= m1_reg;
            neg2_reg  <= neg1_reg;
            lz2_reg   <= lz_next;
            zero2_reg <= (big == '0);
            m3_reg    <= nm_next;
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq3_reg[i] <= 64'(nm_next[i]) * 64'(nm_next[i]);
            end
        end
    end

    // square-root pipeline, one result bit per stage
    logic [63:0]   srem_reg  [SQS+1];
    logic [SW-1:0] sroot_reg [SQS+1];
    logic [NW-1:0] sm_reg    [SQS+1][3];
    logic [2:0]    sneg_reg  [SQS+1];
    logic          szero_reg [SQS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srem_reg[0]  <= sq3_reg[0] + sq3_reg[1] + sq3_reg[2];
            sroot_reg[0] <= '0;
            sm_reg[0]    <= m3_reg;
            sneg_reg[0]  <= neg3_reg;
            szero_reg[0] <= zero3_reg;
        end
    end

    for (genvar s = 0; s < SQS; s++)
    begin : g_sqrt
        localparam int B = SQS - 1 - s;
        logic [63:0] trial;
        logic [SW-1:0] cand;
        always_comb
        begin
            cand  = sroot_reg[s] | (SW'(1) << B);
            trial = 64'(cand) * 64'(cand);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sroot_reg[s+1] <= (trial <= srem_reg[s]) ? cand : sroot_reg[s];
                srem_reg[s+1]  <= srem_reg[s];
                sm_reg[s+1]    <= sm_reg[s];
                sneg_reg[s+1]  <= sneg_reg[s];
                szero_reg[s+1] <= szero_reg[s];
            end
        end
    end

    // restoring division pipeline, three lanes, one quotient bit per stage
    localparam int NumW = NW + 17;
    logic [NumW-1:0] dnum_reg [DVS+1][3];
    logic [SW:0]     drem_reg [DVS+1][3];
    logic [QW-1:0]   dq_reg   [DVS+1][3];
    logic [SW-1:0]   dr_reg   [DVS+1];
    logic [2:0]      dneg_reg [DVS+1];
    logic            dzero_reg[DVS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dnum_reg[0][i] <= {sm_reg[SQS][i], 17'd0};
                drem_reg[0][i] <= '0;
                dq_reg[0][i]   <= '0;
            end
            dr_reg[0]    <= sroot_reg[SQS];
            dneg_reg[0]  <= sneg_reg[SQS];
            dzero_reg[0] <= szero_reg[SQS];
        end
    end

    // quotient fits in QW bits, so leading numerator bits give remainder start
    localparam int PreW = NumW - QW;
    for (genvar s = 0; s < DVS; s++)
    begin : g_div
        logic [SW+1:0] rem [3];
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (s == 0)
                begin
                    rem[i] = {(SW + 2 - PreW)'(0), dnum_reg[s][i][NumW-1 -: PreW]};
                    rem[i] = {rem[i][SW:0], dnum_reg[s][i][QW-1]};
                end
                else
                begin
                    rem[i] = {drem_reg[s][i], dnum_reg[s][i][QW-1-s]};
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem[i] >= {1'b0, 1'b0, dr_reg[s]})
                    begin
                        drem_reg[s+1][i] <= (SW+1)'(rem[i] - {2'b0, dr_reg[s]});
                        dq_reg[s+1][i]   <= {dq_reg[s][i][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[s+1][i] <= (SW+1)'(rem[i]);
                        dq_reg[s+1][i]   <= {dq_reg[s][i][QW-2:0], 1'b0};
                    end
                end
                dnum_reg[s+1]  <= dnum_reg[s];
                dr_reg[s+1]    <= dr_reg[s];
                dneg_reg[s+1]  <= dneg_reg[s];
                dzero_reg[s+1] <= dzero_reg[s];
            end
        end
    end

    localparam int OutW_L = tnu_pkg::OutW;
    typedef logic signed [OutW_L-1:0] unit_l_t;
    logic [OutW_L-1:0] q_next [3];
    unit_l_t res_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_next[i] = OutW_L'((QW + 1)'(dq_reg[DVS][i]) + (QW + 1)'(1)) >> 1;
            if (q_next[i] > tnu_pkg::UnitOne)
            begin
                q_next[i] = tnu_pkg::UnitOne;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dzero_reg[DVS])
                begin
                    res_reg[i] <= '0;
                end
                else
                begin
                    res_reg[i] <= dneg_reg[DVS][i] ? unit_l_t'(-q_next[i])
                                                  : unit_l_t'(q_next[i]);
                end
            end
        end
    end

    assign out_x = res_reg[0];
    assign out_y = res_reg[1];
    assign out_z = res_reg[2];

endmodule

>>> rtl/tnu_cross.sv
// ----------------------------------------------------------------------------
// tnu_cross
// registered cross product of two q1.16 unit vectors
// ----------------------------------------------------------------------------
module tnu_cross
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  tnu_pkg::unit_t    a_x,
    input  tnu_pkg::unit_t    a_y,
    input  tnu_pkg::unit_t    a_z,
    input  tnu_pkg::unit_t    b_x,
    input  tnu_pkg::unit_t    b_y,
    input  tnu_pkg::unit_t    b_z,
    output logic              out_valid,
    output tnu_pkg::comp_t    out_x,
    output tnu_pkg::comp_t    out_y,
    output tnu_pkg::comp_t    out_z
);

    localparam int PW = 2 * tnu_pkg::OutW;
    typedef logic signed [PW-1:0] prod_t;

    prod_t p_reg [6];
    tnu_pkg::comp_t x_reg, y_reg, z_reg;
    logic [1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= a_y * b_z;
            p_reg[1] <= a_z * b_y;
            p_reg[2] <= a_z * b_x;
            p_reg[3] <= a_x * b_z;
            p_reg[4] <= a_x * b_y;
            p_reg[5] <= a_y * b_x;
            x_reg <= tnu_pkg::CompW'(p_reg[0] - p_reg[1]);
            y_reg <= tnu_pkg::CompW'(p_reg[2] - p_reg[3]);
            z_reg <= tnu_pkg::CompW'(p_reg[4] - p_reg[5]);
        end
    end

    assign out_valid = vld_reg[1];
    assign out_x = x_reg;
    assign out_y = y_reg;
    assign out_z = z_reg;

endmodule

>>> rtl/triangle_normal_unit.sv
// ----------------------------------------------------------------------------
// triangle_normal_unit
// unit surface normal of a triangle given in q16.16 vertices
// ----------------------------------------------------------------------------
// channel   direction   payload
// in        sink        v0_x..v2_z, 9 x 32-bit signed q16.16
// out       source      normal_x..normal_z, 3 x 18-bit signed q1.16
//
// one triangle per cycle while not stalled; stages in order: edge registers,
// edge normalizers (root and quotient one bit per stage), cross product,
// normal normalizer
// reset clears only the valid bits
// a stall freezes the whole pipeline; in_stall is out_stall qualified by out_valid
// ----------------------------------------------------------------------------
module triangle_normal_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] v0_x,
    input  logic signed [31:0] v0_y,
    input  logic signed [31:0] v0_z,
    input  logic signed [31:0] v1_x,
    input  logic signed [31:0] v1_y,
    input  logic signed [31:0] v1_z,
    input  logic signed [31:0] v2_x,
    input  logic signed [31:0] v2_y,
    input  logic signed [31:0] v2_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] normal_x,
    output logic signed [17:0] normal_y,
    output logic signed [17:0] normal_z
);

    localparam int CW = tnu_pkg::CompW;

    logic en;
    assign en = !(out_valid && out_stall);
    assign in_stall = !en;

    tnu_pkg::comp_t e1_reg [3];
    tnu_pkg::comp_t e2_reg [3];
    logic e_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg[0] <= CW'(v1_x) - CW'(v0_x);
            e1_reg[1] <= CW'(v1_y) - CW'(v0_y);
            e1_reg[2] <= CW'(v1_z) - CW'(v0_z);
            e2_reg[0] <= CW'(v2_x) - CW'(v0_x);
            e2_reg[1] <= CW'(v2_y) - CW'(v0_y);
            e2_reg[2] <= CW'(v2_z) - CW'(v0_z);
        end
    end

    logic a_vld, b_vld, c_vld;
    tnu_pkg::unit_t a_x, a_y, a_z, b_x, b_y, b_z;
    tnu_pkg::comp_t c_x, c_y, c_z;

    tnu_normalize u_norm_a
    (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(e_vld_reg),
        .in_x(e1_reg[0]), .in_y(e1_reg[1]), .in_z(e1_reg[2]),
        .out_valid(a_vld), .out_x(a_x), .out_y(a_y), .out_z(a_z)
    );

    tnu_normalize u_norm_b
    (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(e_vld_reg),
        .in_x(e2_reg[0]), .in_y(e2_reg[1]), .in_z(e2_reg[2]),
        .out_valid(b_vld), .out_x(b_x), .out_y(b_y), .out_z(b_z)
    );

    tnu_cross u_cross
    (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(a_vld && b_vld),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .out_valid(c_vld), .out_x(c_x), .out_y(c_y), .out_z(c_z)
    );

    tnu_normalize u_norm_n
    (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(c_vld),
        .in_x(c_x), .in_y(c_y), .in_z(c_z),
        .out_valid(out_valid), .out_x(normal_x), .out_y(normal_y), .out_z(normal_z)
    );

endmodule
